### rtl/core/ultrasonic_range_proximity_alarm_defines.svh
// Assertion macros used by the proximity alarm top-level RTL.
`ifndef ULTRASONIC_RANGE_PROXIMITY_ALARM_DEFINES_SVH
`define ULTRASONIC_RANGE_PROXIMITY_ALARM_DEFINES_SVH

// Same-cycle implication, sampled on clock, disabled in reset.
`define URPA_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, disabled in reset.
`define URPA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/urpa_pkg.sv
// Types and constants for the ultrasonic ranging proximity alarm.
package urpa_pkg;

   localparam int NUM_SENSORS = 4;
   localparam int TICK_W      = 16;
   localparam int DIST_W      = 21;
   localparam int OUT_W       = 20;
   localparam int CSR_IDX_W   = 2;

   localparam logic [TICK_W-1:0] TICK_WRAP     = 16'hFFFF;
   localparam logic [DIST_W-1:0] TICK_HMM      = 21'd17;
   localparam logic [DIST_W-1:0] RANGE_MAX_HMM = 21'd400000;
   localparam logic [DIST_W-1:0] NONE_NEAREST  = 21'h1FFFFF;
   localparam logic [OUT_W-1:0]  OUT_OF_RANGE  = 20'hFFFFF;

   localparam logic [DIST_W-1:0] DEAD_RESET  = 21'd10000;
   localparam logic [DIST_W-1:0] WARN_RESET  = 21'd20000;
   localparam logic [DIST_W-1:0] CLEAR_RESET = 21'd30000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEAD  = 2'd0,
      CSR_WARN  = 2'd1,
      CSR_CLEAR = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [TICK_W-1:0] start;
      logic [TICK_W-1:0] stop;
   } echo_type;

   typedef struct packed {
      logic [DIST_W-1:0] dead;
      logic [DIST_W-1:0] warn;
      logic [DIST_W-1:0] clear;
   } thr_type;

   typedef struct packed {
      logic [DIST_W-1:0] nearest;
      logic              warning;
      logic              dead;
   } alarm_type;

endpackage

### rtl/core/ultrasonic_range_proximity_alarm.sv
// A req beat passes through the input register, then the result register, to the rsp beat.
// Throughput: one round per cycle while rsp is not stalled; the result register holds per-sensor distance and flags.
// A stalled rsp beat holds the input register too, so req_stall rises only when both are full.
// Reset (synchronous): distances and flags clear to zero, thresholds load defaults,
// both stages empty. csr writes are always accepted.
`include "ultrasonic_range_proximity_alarm_defines.svh"

module ultrasonic_range_proximity_alarm
   import urpa_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [TICK_W-1:0]       req_start_0,
   input  logic [TICK_W-1:0]       req_end_0,
   input  logic [TICK_W-1:0]       req_start_1,
   input  logic [TICK_W-1:0]       req_end_1,
   input  logic [TICK_W-1:0]       req_start_2,
   input  logic [TICK_W-1:0]       req_end_2,
   input  logic [TICK_W-1:0]       req_start_3,
   input  logic [TICK_W-1:0]       req_end_3,
   input  logic [NUM_SENSORS-1:0]  req_capture_mask,

   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [OUT_W-1:0] rsp_dist_0,
   output logic signed [OUT_W-1:0] rsp_dist_1,
   output logic signed [OUT_W-1:0] rsp_dist_2,
   output logic signed [OUT_W-1:0] rsp_dist_3,
   output logic [DIST_W-1:0]       rsp_nearest,
   output logic                    rsp_warning,
   output logic                    rsp_dead,

   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [DIST_W-1:0]       csr_wdata
);

   thr_type                thr_ff;
   thr_type                thr_in;

   logic                   s1_vld_ff;
   logic                   s1_vld_in;
   echo_type               echo_ff [NUM_SENSORS];
   echo_type               echo_in [NUM_SENSORS];
   logic [NUM_SENSORS-1:0] mask_ff;

   logic                   rsp_vld_ff;
   logic                   rsp_vld_in;
   logic [OUT_W-1:0]       dist_ff [NUM_SENSORS];
   logic [OUT_W-1:0]       dist_in [NUM_SENSORS];
   logic [DIST_W-1:0]      nearest_ff;
   logic                   warning_ff;
   logic                   dead_ff;

   logic [DIST_W-1:0]      dist_raw   [NUM_SENSORS];
   logic [OUT_W-1:0]       dist_clamp [NUM_SENSORS];
   alarm_type              alarm;

   logic                   out_busy;
   logic                   s1_load;
   logic                   advance;

   // ---------------- configuration ----------------
   assign csr_ready = 1'b1;

   always_comb begin
      thr_in = thr_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DEAD:  thr_in.dead  = csr_wdata;
            CSR_WARN:  thr_in.warn  = csr_wdata;
            CSR_CLEAR: thr_in.clear = csr_wdata;
            default:   thr_in = thr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff.dead  <= DEAD_RESET;
         thr_ff.warn  <= WARN_RESET;
         thr_ff.clear <= CLEAR_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

   // ---------------- handshake ----------------
   assign out_busy  = rsp_vld_ff && rsp_stall;
   assign req_stall = s1_vld_ff && out_busy;
   assign s1_load   = req_valid && !req_stall;
   assign advance   = s1_vld_ff && !out_busy;

   assign s1_vld_in  = s1_load ? 1'b1 : (advance ? 1'b0 : s1_vld_ff);
   assign rsp_vld_in = advance ? 1'b1 : out_busy;

   // ---------------- input register ----------------
   assign echo_in[0] = '{start: req_start_0, stop: req_end_0};
   assign echo_in[1] = '{start: req_start_1, stop: req_end_1};
   assign echo_in[2] = '{start: req_start_2, stop: req_end_2};
   assign echo_in[3] = '{start: req_start_3, stop: req_end_3};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         echo_ff <= echo_in;
         mask_ff <= req_capture_mask;
      end
   end

   // ---------------- datapath ----------------
   for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_sensor
      urpa_sensor u_sensor (
         .echo       (echo_ff[g]),
         .dist_raw   (dist_raw[g]),
         .dist_clamp (dist_clamp[g])
      );
      assign dist_in[g] = mask_ff[g] ? dist_clamp[g] : dist_ff[g];
   end

   urpa_alarm u_alarm (
      .dist_raw     (dist_raw),
      .capture_mask (mask_ff),
      .thr          (thr_ff),
      .warning_cur  (warning_ff),
      .dead_cur     (dead_ff),
      .alarm        (alarm)
   );

   // ---------------- result register / sensor state ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
         warning_ff <= 1'b0;
         dead_ff    <= 1'b0;
         for (int i = 0; i < NUM_SENSORS; i++) begin
            dist_ff[i] <= '0;
         end
      end else begin
         rsp_vld_ff <= rsp_vld_in;
         if (advance) begin
            warning_ff <= alarm.warning;
            dead_ff    <= alarm.dead;
            dist_ff    <= dist_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         nearest_ff <= alarm.nearest;
      end
   end

   assign rsp_valid   = rsp_vld_ff;
   assign rsp_dist_0  = $signed(dist_ff[0]);
   assign rsp_dist_1  = $signed(dist_ff[1]);
   assign rsp_dist_2  = $signed(dist_ff[2]);
   assign rsp_dist_3  = $signed(dist_ff[3]);
   assign rsp_nearest = nearest_ff;
   assign rsp_warning = warning_ff;
   assign rsp_dead    = dead_ff;

   // ---------------- assertions ----------------
   `URPA_ASSERT_NEXT(a_advance_fills_rsp, advance, rsp_vld_ff, "round lost on way to result register")
   `URPA_ASSERT_NEXT(a_flags_hold, !advance, $stable(warning_ff) && $stable(dead_ff), "flags changed without a round")
   `URPA_ASSERT_IMPL(a_none_clears_flags, rsp_vld_ff && nearest_ff == NONE_NEAREST, !warning_ff && !dead_ff, "flags set with no nearest echo")
   `URPA_ASSERT_IMPL(a_stall_only_full, req_stall, s1_vld_ff && rsp_vld_ff, "req stalled with a free stage")

endmodule

### rtl/core/urpa_sensor.sv
// One sensor's echo width to distance conversion and range clamp.
module urpa_sensor
   import urpa_pkg::*;
(
   input  echo_type          echo,
   output logic [DIST_W-1:0] dist_raw,
   output logic [OUT_W-1:0]  dist_clamp
);

   logic [TICK_W-1:0] ticks;

   // wrapped capture: counter rolled over between echo start and echo stop (also taken when start equals stop)
   assign ticks = (echo.start < echo.stop) ? (echo.stop - echo.start)
                                           : (TICK_WRAP - echo.start + echo.stop);

   assign dist_raw   = DIST_W'(ticks) * TICK_HMM;
   assign dist_clamp = (dist_raw > RANGE_MAX_HMM) ? OUT_OF_RANGE : dist_raw[OUT_W-1:0];

endmodule

### rtl/core/urpa_alarm.sv
// Nearest-distance selection and hysteresis update of warning and dead flags.
module urpa_alarm
   import urpa_pkg::*;
(
   input  logic [DIST_W-1:0]      dist_raw [NUM_SENSORS],
   input  logic [NUM_SENSORS-1:0] capture_mask,
   input  thr_type                thr,
   input  logic                   warning_cur,
   input  logic                   dead_cur,
   output alarm_type              alarm
);

   logic [DIST_W-1:0]      cand [NUM_SENSORS];
   logic [NUM_SENSORS-1:0] hit;
   logic [DIST_W-1:0]      min_lo;
   logic [DIST_W-1:0]      min_hi;
   logic [DIST_W-1:0]      m;

   always_comb begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
         hit[i]  = capture_mask[i] && (dist_raw[i] != '0);
         cand[i] = hit[i] ? dist_raw[i] : NONE_NEAREST;
      end
   end

   assign min_lo = (cand[1] < cand[0]) ? cand[1] : cand[0];
   assign min_hi = (cand[3] < cand[2]) ? cand[3] : cand[2];
   assign m      = (min_hi < min_lo) ? min_hi : min_lo;

   always_comb begin
      logic w;
      logic d;
      w = warning_cur;
      d = dead_cur;
      if (hit == '0) begin
         w = 1'b0;
         d = 1'b0;
      end else begin
         if (m < thr.warn) w = 1'b1;
         if (m < thr.dead) d = 1'b1;
         // rules apply in order; no check of threshold ordering
         if (m > thr.warn && m < thr.clear) begin
            d = 1'b0;
            w = 1'b1;
         end else if (m > thr.clear) begin
            d = 1'b0;
            w = 1'b0;
         end
      end
      alarm.nearest = m;
      alarm.warning = w;
      alarm.dead    = d;
   end

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the ultrasonic proximity alarm: directed rounds, then random rounds.
module testbench
   import urpa_pkg::*;
();

   localparam int CYCLE_LIMIT   = 400000;
   localparam int RANDOM_ROUNDS = 150;
   localparam int NUM_PHASES    = 6;

   typedef struct packed {
      logic [NUM_SENSORS-1:0][OUT_W-1:0] dists;
      logic [DIST_W-1:0]                 near;
      logic                              warn;
      logic                              dead;
   } range_beat_t;

   // One directed round; expected fields are used only when known is set.
   // Packed arrays list sensor 3 first.
   typedef struct packed {
      logic [NUM_SENSORS-1:0][TICK_W-1:0] st;
      logic [NUM_SENSORS-1:0][TICK_W-1:0] en;
      logic [NUM_SENSORS-1:0]             mask;
      logic                               known;
      logic [NUM_SENSORS-1:0][OUT_W-1:0]  dists;
      logic [DIST_W-1:0]                  near;
      logic                               warn;
      logic                               dead;
   } round_row_t;

   localparam logic [TICK_W-1:0] Z = 16'h0000;
   localparam logic [TICK_W-1:0] F = 16'hFFFF;
   localparam logic [OUT_W-1:0]  X = OUT_OF_RANGE;

   round_row_t directed_rounds [20] = '{
      // nothing captured right after reset
      '{st: {Z, Z, Z, Z}, en: {Z, Z, Z, Z}, mask: 4'h0, known: 1'b1,
        dists: {20'd0, 20'd0, 20'd0, 20'd0}, near: NONE_NEAREST, warn: 1'b0, dead: 1'b0},
      // one tick on every sensor
      '{st: {Z, Z, Z, Z}, en: {16'd1, 16'd1, 16'd1, 16'd1}, mask: 4'hF, known: 1'b1,
        dists: {20'd17, 20'd17, 20'd17, 20'd17}, near: 21'd17, warn: 1'b1, dead: 1'b1},
      // zero-width echo on sensor 0, no nonzero distance this round
      '{st: {Z, Z, Z, F}, en: {Z, Z, Z, Z}, mask: 4'h1, known: 1'b1,
        dists: {20'd17, 20'd17, 20'd17, 20'd0}, near: NONE_NEAREST, warn: 1'b0, dead: 1'b0},
      // longest echo everywhere: beyond range, nearest unclamped
      '{st: {Z, Z, Z, Z}, en: {F, F, F, F}, mask: 4'hF, known: 1'b1,
        dists: {X, X, X, X}, near: 21'd1114095, warn: 1'b0, dead: 1'b0},
      // start equal to end counts a full wrap
      '{st: {Z, Z, 16'h1234, Z}, en: {Z, Z, 16'h1234, Z}, mask: 4'h2, known: 1'b1,
        dists: {X, X, X, X}, near: 21'd1114095, warn: 1'b0, dead: 1'b0},
      // last tick count inside the range
      '{st: {Z, Z, Z, Z}, en: {Z, 16'd23529, Z, Z}, mask: 4'h4, known: 1'b1,
        dists: {X, 20'd399993, X, X}, near: 21'd399993, warn: 1'b0, dead: 1'b0},
      // first tick count beyond the range
      '{st: {Z, Z, Z, Z}, en: {16'd23530, Z, Z, Z}, mask: 4'h8, known: 1'b1,
        dists: {X, 20'd399993, X, X}, near: 21'd400010, warn: 1'b0, dead: 1'b0},
      // timer wrap between start and end
      '{st: {Z, Z, Z, 16'hFFF0}, en: {Z, Z, Z, 16'h0010}, mask: 4'h1, known: 1'b0,
        dists: '0, near: '0, warn: 1'b0, dead: 1'b0},
      // mixed round: minimum skips the zero distance
      '{st: {Z, Z, F, Z}, en: {16'd600, 16'd2000, Z, 16'd1000}, mask: 4'hF, known: 1'b0,
        dists: '0, near: '0, warn: 1'b0, dead: 1'b0},
      // hysteresis walk on the default thresholds
      '{st: {Z, Z, Z, Z}, en: {Z, Z, Z, 16'd1400}, mask: 4'h1, known: 1'b0,
        dists: '0, near: '0, warn: 1'b0, dead: 1'b0},
      '{st: {Z, Z, Z, Z}, en: {Z, Z, 16'd100, Z}, mask: 4'h2, known: 1'b0,
        dists: '0, near: '0, warn: 1'b0, dead: 1'b0},
      '{st: {Z, Z, Z, Z}, en: {Z, Z, 16'd1000, Z}, mask: 4'h2, known: 1'b0,
        dists: '0, near: '0, warn: 1'b0, dead: 1'b0},
      '{st: {Z, Z, Z, Z}, en: {Z, Z, 16'd2000, Z}, mask: 4'h2, known: 1'b0,
        dists: '0, near: '0, warn: 1'b0, dead: 1'b0},
      '{st: {Z, Z, Z, Z}, en: {Z, Z, 16'd1000, Z}, mask: 4'h2, known: 1'b0,
        dists: '0, near: '0, warn: 1'b0, dead: 1'b0},
      '{st: {Z, Z, Z, Z}, en: {Z, 16'd1400, Z, Z}, mask: 4'h4, known: 1'b0,
        dists: '0, near: '0, warn: 1'b0, dead: 1'b0},
      // every field at its maximum
      '{st: {F, F, F, F}, en: {F, F, F, F}, mask: 4'hF, known: 1'b0,
        dists: '0, near: '0, warn: 1'b0, dead: 1'b0},
      // every echo zero width
      '{st: {F, F, F, F}, en: {Z, Z, Z, Z}, mask: 4'hF, known: 1'b1,
        dists: {20'd0, 20'd0, 20'd0, 20'd0}, near: NONE_NEAREST, warn: 1'b0, dead: 1'b0},
      '{st: {16'hA5A5, 16'h5A5A, 16'hA5A5, 16'h5A5A},
        en: {16'h5A5A, 16'hA5A5, 16'h5A5A, 16'hA5A5}, mask: 4'hF, known: 1'b0,
        dists: '0, near: '0, warn: 1'b0, dead: 1'b0},
      '{st: {16'h8000, Z, Z, Z}, en: {16'h8001, Z, Z, Z}, mask: 4'h8, known: 1'b0,
        dists: '0, near: '0, warn: 1'b0, dead: 1'b0},
      // uncaptured garbage: distances hold, flags clear
      '{st: {16'h1357, 16'h2468, 16'h9BDF, 16'hACE0},
        en: {16'h0001, 16'h7777, 16'h0002, 16'hFFFE}, mask: 4'h0, known: 1'b0,
        dists: '0, near: '0, warn: 1'b0, dead: 1'b0}
   };

   logic clock;
   logic reset = 1'b1;

   logic                               req_valid = 1'b0;
   wire  logic                         req_stall;
   logic [NUM_SENSORS-1:0][TICK_W-1:0] req_st = '0;
   logic [NUM_SENSORS-1:0][TICK_W-1:0] req_en = '0;
   logic [NUM_SENSORS-1:0]             req_mask = '0;

   wire  logic                    rsp_valid;
   logic                          rsp_stall = 1'b0;
   wire  logic signed [OUT_W-1:0] rsp_dist_0, rsp_dist_1, rsp_dist_2, rsp_dist_3;
   wire  logic [DIST_W-1:0]       rsp_nearest;
   wire  logic                    rsp_warning, rsp_dead;

   logic                 csr_valid = 1'b0;
   wire  logic           csr_ready;
   csr_index_type        csr_index = CSR_DEAD;
   logic [DIST_W-1:0]    csr_wdata = '0;

   // predictor state
   logic [NUM_SENSORS-1:0][OUT_W-1:0] sensor_dist;
   logic                              warn_flag, dead_flag;
   logic [DIST_W-1:0]                 dead_thr, warn_thr, clear_thr;

   range_beat_t pending_alarms [$];
   int error_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;

   ultrasonic_range_proximity_alarm uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_start_0      (req_st[0]),
      .req_end_0        (req_en[0]),
      .req_start_1      (req_st[1]),
      .req_end_1        (req_en[1]),
      .req_start_2      (req_st[2]),
      .req_end_2        (req_en[2]),
      .req_start_3      (req_st[3]),
      .req_end_3        (req_en[3]),
      .req_capture_mask (req_mask),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_dist_0       (rsp_dist_0),
      .rsp_dist_1       (rsp_dist_1),
      .rsp_dist_2       (rsp_dist_2),
      .rsp_dist_3       (rsp_dist_3),
      .rsp_nearest      (rsp_nearest),
      .rsp_warning      (rsp_warning),
      .rsp_dead         (rsp_dead),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   // Range one round: update per-sensor distances, find the nearest echo, step the flags.
   function automatic range_beat_t range_round(
      logic [NUM_SENSORS-1:0][TICK_W-1:0] st,
      logic [NUM_SENSORS-1:0][TICK_W-1:0] en,
      logic [NUM_SENSORS-1:0]             mask
   );
      range_beat_t       r;
      logic [TICK_W-1:0] ticks;
      logic [DIST_W-1:0] d;
      logic [DIST_W-1:0] m;
      bit                found;
      m = NONE_NEAREST;
      found = 1'b0;
      for (int i = 0; i < NUM_SENSORS; i++) begin
         if (mask[i]) begin
            // wrap case is one short of a true modular difference
            ticks = (st[i] < en[i]) ? en[i] - st[i] : TICK_WRAP - st[i] + en[i];
            d = DIST_W'(ticks) * TICK_HMM;
            if (d != '0 && (!found || d < m)) begin
               m = d;
               found = 1'b1;
            end
            sensor_dist[i] = (d > RANGE_MAX_HMM) ? OUT_OF_RANGE : d[OUT_W-1:0];
         end
      end
      if (!found) begin
         warn_flag = 1'b0;
         dead_flag = 1'b0;
      end else begin
         if (m < warn_thr) warn_flag = 1'b1;
         if (m < dead_thr) dead_flag = 1'b1;
         if (m > warn_thr && m < clear_thr) begin
            dead_flag = 1'b0;
            warn_flag = 1'b1;
         end else if (m > clear_thr) begin
            dead_flag = 1'b0;
            warn_flag = 1'b0;
         end
      end
      r.dists = sensor_dist;
      r.near = m;
      r.warn = warn_flag;
      r.dead = dead_flag;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (error_count < 100)
         $display("mismatch %s: got %0h, expected %0h (cycle %0d)", what, got, want,
                  cycle_count);
      error_count++;
   endtask

   task automatic check_beat();
      range_beat_t got, want;
      got.dists = {rsp_dist_3, rsp_dist_2, rsp_dist_1, rsp_dist_0};
      got.near = rsp_nearest;
      got.warn = rsp_warning;
      got.dead = rsp_dead;
      if (pending_alarms.size() == 0) begin
         report_mismatch("beat with nothing pending", 32'(got.near), 32'd0);
      end else begin
         want = pending_alarms.pop_front();
         for (int i = 0; i < NUM_SENSORS; i++)
            if (got.dists[i] !== want.dists[i])
               report_mismatch($sformatf("dist_%0d", i), 32'(got.dists[i]),
                               32'(want.dists[i]));
         if (got.near !== want.near)
            report_mismatch("nearest", 32'(got.near), 32'(want.near));
         if (got.warn !== want.warn)
            report_mismatch("warning", 32'(got.warn), 32'(want.warn));
         if (got.dead !== want.dead)
            report_mismatch("dead", 32'(got.dead), 32'(want.dead));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_beat();
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic send_round(
      logic [NUM_SENSORS-1:0][TICK_W-1:0] st,
      logic [NUM_SENSORS-1:0][TICK_W-1:0] en,
      logic [NUM_SENSORS-1:0]             mask,
      logic                               known,
      range_beat_t                        typed
   );
      range_beat_t want;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_st    <= st;
      req_en    <= en;
      req_mask  <= mask;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      want = range_round(st, en, mask);
      if (known) want = typed;
      pending_alarms.push_back(want);
   endtask

   // Echo pair aimed near a threshold, the range edge, or one of the odd cases.
   task automatic make_echo(output logic [TICK_W-1:0] s, output logic [TICK_W-1:0] e);
      int t;
      int thr;
      t = 0;
      case ($urandom_range(9))
         0, 1, 2, 3: begin
            case ($urandom_range(2))
               0:       thr = int'(dead_thr);
               1:       thr = int'(warn_thr);
               default: thr = int'(clear_thr);
            endcase
            t = thr / 17 + int'($urandom_range(4)) - 2;
         end
         5: t = int'($urandom_range(3));
         6: t = 23528 + int'($urandom_range(3));
         9: t = int'($urandom_range(3000));
         default: t = 0;
      endcase
      if (t < 0) t = 0;
      if (t > 65535) t = 65535;
      s = TICK_W'($urandom_range(65535 - t));
      e = s + TICK_W'(t);
      case ($urandom_range(9))
         4: begin
            s = TICK_W'($urandom);
            e = TICK_W'($urandom);
         end
         7: begin
            s = F;
            e = Z;
         end
         8: e = s;
         default: ;
      endcase
   endtask

   task automatic program_thresholds(logic [DIST_W-1:0] d, logic [DIST_W-1:0] w,
                                     logic [DIST_W-1:0] c);
      csr_index_type     idx [3];
      logic [DIST_W-1:0] val [3];
      idx = '{CSR_DEAD, CSR_WARN, CSR_CLEAR};
      val = '{d, w, c};
      for (int k = 0; k < 3; k++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[k];
         csr_wdata <= val[k];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         case (idx[k])
            CSR_DEAD:  dead_thr  = val[k];
            CSR_WARN:  warn_thr  = val[k];
            CSR_CLEAR: clear_thr = val[k];
            default:   ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   task automatic set_idling(int mode);
      case (mode)
         0: begin
            send_idle_pct = 35;
            stall_pct     = 88;
         end
         1: begin
            send_idle_pct = 88;
            stall_pct     = 35;
         end
         default: begin
            send_idle_pct = 0;
            stall_pct     = 0;
         end
      endcase
   endtask

   initial begin
      logic [NUM_SENSORS-1:0][TICK_W-1:0] st, en;
      logic [DIST_W-1:0]                  d, w, c;
      range_beat_t                        typed;
      sensor_dist = '0;
      warn_flag   = 1'b0;
      dead_flag   = 1'b0;
      dead_thr    = DEAD_RESET;
      warn_thr    = WARN_RESET;
      clear_thr   = CLEAR_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      set_idling(0);

      foreach (directed_rounds[n]) begin
         typed.dists = directed_rounds[n].dists;
         typed.near = directed_rounds[n].near;
         typed.warn = directed_rounds[n].warn;
         typed.dead = directed_rounds[n].dead;
         send_round(directed_rounds[n].st, directed_rounds[n].en, directed_rounds[n].mask,
                    directed_rounds[n].known, typed);
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         req_valid <= 1'b0;
         while (pending_alarms.size() != 0) @(posedge clock);
         repeat (4) @(posedge clock);
         set_idling(phase / 2);
         case (phase)
            0: begin
               d = '0;
               w = '0;
               c = '0;
            end
            1: begin
               d = 21'd2097150;
               w = 21'd2097150;
               c = 21'd2097150;
            end
            2: begin
               d = DIST_W'(17 * $urandom_range(1000, 200));
               w = d + DIST_W'(17 * $urandom_range(1500));
               c = w + DIST_W'(17 * $urandom_range(1500));
            end
            3: begin
               // no ordering between the thresholds
               d = DIST_W'(17 * $urandom_range(4000));
               w = DIST_W'(17 * $urandom_range(4000));
               c = DIST_W'(17 * $urandom_range(4000));
            end
            4: begin
               d = 21'd10200;
               w = 21'd20400;
               c = 21'd30600;
            end
            default: begin
               d = DIST_W'($urandom_range(2097150));
               w = DIST_W'($urandom_range(2097150));
               c = DIST_W'($urandom_range(2097150));
            end
         endcase
         program_thresholds(d, w, c);
         typed = '0;
         for (int n = 0; n < RANDOM_ROUNDS; n++) begin
            for (int i = 0; i < NUM_SENSORS; i++) make_echo(st[i], en[i]);
            send_round(st, en, NUM_SENSORS'($urandom_range(15)), 1'b0, typed);
         end
      end

      req_valid <= 1'b0;
      while (pending_alarms.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/urpa_pkg.sv
rtl/core/urpa_sensor.sv
rtl/core/urpa_alarm.sv
rtl/core/ultrasonic_range_proximity_alarm.sv
tb/sv/testbench.sv
